### sv/mdst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdst_pkg: shared definitions for the step-pulse tone generator
// Request codes, fixed field widths and default sizes used across the block.
// ----------------------------------------------------------------------------
package mdst_pkg;

    localparam int OP_BITS     = 2;
    localparam int CH_BITS     = 3;
    localparam int PERIOD_IN_W = 14;
    localparam int MASK_BITS   = 8;
    localparam int MAX_BITS    = 8;
    // The step count can run one past the largest limit before it is cleared.
    localparam int STEP_BITS   = 9;

    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;

    localparam int DEF_NUM_CHANNELS = 8;
    localparam int DEF_PERIOD_BITS  = 14;

    localparam logic [MAX_BITS-1:0] MAX_STEP_RESET = 8'd80;

    typedef logic [OP_BITS-1:0] t_op;

    localparam t_op OP_TICK = 2'd0;
    localparam t_op OP_PLAY = 2'd1;
    localparam t_op OP_STOP = 2'd2;

endpackage

### sv/mdst_chan_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdst_chan_mem: per-channel state memory
// One write port and one read port with registered read data. Entries that
// were never written since reset read back as the reset record.
// ----------------------------------------------------------------------------
module mdst_chan_mem #(
    parameter int                 DEPTH     = 8,
    parameter int                 IDX_W     = 3,
    parameter int                 WIDTH     = 38,
    parameter logic [WIDTH-1:0]   INIT_WORD = '0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_word;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_word : INIT_WORD;

endmodule

### sv/mdst_step_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdst_step_alu: one channel's update for a tick
// Advances the tick counter, issues a step when it reaches the period and
// reverses the direction once the step count passes the limit.
// ----------------------------------------------------------------------------
module mdst_step_alu #(
    parameter int PERIOD_BITS = 14
) (
    input  logic                           i_active,
    input  logic [PERIOD_BITS-1:0]         i_period,
    input  logic [PERIOD_BITS-1:0]         i_tick,
    input  logic [mdst_pkg::STEP_BITS-1:0] i_steps,
    input  logic                           i_dir,
    input  logic [mdst_pkg::MAX_BITS-1:0]  i_max_step,
    output logic [PERIOD_BITS-1:0]         o_tick,
    output logic [mdst_pkg::STEP_BITS-1:0] o_steps,
    output logic                           o_dir,
    output logic                           o_step
);

    logic [PERIOD_BITS-1:0]         tick_inc;
    logic [mdst_pkg::STEP_BITS-1:0] steps_inc;

    assign tick_inc  = i_tick + PERIOD_BITS'(1);
    assign steps_inc = i_steps + mdst_pkg::STEP_BITS'(1);

    always_comb begin
        o_tick  = i_tick;
        o_steps = i_steps;
        o_dir   = i_dir;
        o_step  = 1'b0;
        if (i_active) begin
            o_tick = tick_inc;
            if (tick_inc >= i_period) begin
                o_step  = 1'b1;
                o_tick  = '0;
                o_steps = steps_inc;
                if (steps_inc > mdst_pkg::STEP_BITS'(i_max_step)) begin
                    o_dir   = ~i_dir;
                    o_steps = '0;
                end
            end
        end
    end

endmodule

### sv/multi_drive_step_tone_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_drive_step_tone_generator_unit: multi-channel step-pulse tone generator
//
// Requests enter on the s_axis channel: tdata carries op, channel and
// period_ticks. A play request loads a channel's period and starts it, a stop
// request halts it, and a tick request advances every channel by one tick of
// the time base. Each tick yields one result on m_axis with the step mask and
// the direction mask; play, stop and unused op codes yield none.
// Channel state is kept in a single-port-read, single-port-write memory. A
// play or stop passes through accept, read and write back in turn.
// A tick sweeps the channels one per cycle through the memory read and
// write-back, then loads the result into the output register, so the
// channel count sets the throughput.
// The result sits in an output register; the next request is taken while it
// waits. A further tick that finishes while the receiver still stalls holds
// its result until the register frees up.
// Reset stops all channels, clears counters, sets every direction forward
// and loads the step limit with 80. The user must write the limit register
// via i_cfg_we / i_cfg_wdata while no request is in progress (not enforced).
// ----------------------------------------------------------------------------
module multi_drive_step_tone_generator_unit #(
    parameter int NUM_CHANNELS = mdst_pkg::DEF_NUM_CHANNELS,
    parameter int PERIOD_BITS  = mdst_pkg::DEF_PERIOD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mdst_pkg::MAX_BITS-1:0]   i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] op, [4:2] channel, [18:5] period_ticks, [23:19] zero
    input  logic [mdst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] step_mask, [15:8] direction_mask
    output logic [mdst_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W  = IDX_W + 1;
    localparam int SB     = mdst_pkg::STEP_BITS;
    localparam int MB     = mdst_pkg::MASK_BITS;
    localparam int REC_W  = 2 * PERIOD_BITS + SB + 2;
    // Record layout from the lowest bit: active, period, tick, steps, direction.
    localparam logic [REC_W-1:0] REC_INIT = {1'b1, {(REC_W-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CMD_RD = 5'b00010,
        S_CMD_WR = 5'b00100,
        S_TICK   = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [mdst_pkg::MAX_BITS-1:0] r_max_step;

    mdst_pkg::t_op          in_op;
    logic [mdst_pkg::CH_BITS-1:0] in_ch;
    logic [PERIOD_BITS-1:0] in_period;
    logic                   in_fire;
    logic                   in_ch_ok;

    mdst_pkg::t_op          r_op, n_op;
    logic [IDX_W-1:0]       r_ch, n_ch;
    logic [PERIOD_BITS-1:0] r_period, n_period;

    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_pend, n_pend;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;
    logic [MB-1:0]          r_step_acc, n_step_acc;
    logic [MB-1:0]          r_dir_acc, n_dir_acc;

    logic                   r_out_valid, n_out_valid;
    logic [MB-1:0]          r_out_step, n_out_step;
    logic [MB-1:0]          r_out_dir, n_out_dir;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [REC_W-1:0]       mem_wdata;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;
    logic [REC_W-1:0]       mem_rdata;

    logic                   rd_active;
    logic [PERIOD_BITS-1:0] rd_period;
    logic [PERIOD_BITS-1:0] rd_tick;
    logic [SB-1:0]          rd_steps;
    logic                   rd_dir;

    logic [PERIOD_BITS-1:0] alu_tick;
    logic [SB-1:0]          alu_steps;
    logic                   alu_dir;
    logic                   alu_step;

    assign in_op     = s_axis_tdata[1:0];
    assign in_ch     = s_axis_tdata[4:2];
    assign in_period = PERIOD_BITS'(s_axis_tdata[18:5]);
    assign in_ch_ok  = (32'(in_ch) < NUM_CHANNELS);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign rd_active = mem_rdata[0];
    assign rd_period = mem_rdata[PERIOD_BITS:1];
    assign rd_tick   = mem_rdata[2*PERIOD_BITS:PERIOD_BITS+1];
    assign rd_steps  = mem_rdata[2*PERIOD_BITS+SB:2*PERIOD_BITS+1];
    assign rd_dir    = mem_rdata[REC_W-1];

    mdst_chan_mem #(
        .DEPTH     (NUM_CHANNELS),
        .IDX_W     (IDX_W),
        .WIDTH     (REC_W),
        .INIT_WORD (REC_INIT)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    mdst_step_alu #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_alu (
        .i_active   (rd_active),
        .i_period   (rd_period),
        .i_tick     (rd_tick),
        .i_steps    (rd_steps),
        .i_dir      (rd_dir),
        .i_max_step (r_max_step),
        .o_tick     (alu_tick),
        .o_steps    (alu_steps),
        .o_dir      (alu_dir),
        .o_step     (alu_step)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ch        = r_ch;
        n_period    = r_period;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_step_acc  = r_step_acc;
        n_dir_acc   = r_dir_acc;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_step  = r_out_step;
        n_out_dir   = r_out_dir;
        mem_we      = 1'b0;
        mem_waddr   = r_pend_idx;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = r_ch;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op     = in_op;
                    n_ch     = IDX_W'(in_ch);
                    n_period = in_period;
                    if (in_op == mdst_pkg::OP_TICK) begin
                        n_cnt      = '0;
                        n_step_acc = '0;
                        n_dir_acc  = '0;
                        n_state    = S_TICK;
                    end else if ((in_op == mdst_pkg::OP_PLAY ||
                                  in_op == mdst_pkg::OP_STOP) && in_ch_ok) begin
                        n_state = S_CMD_RD;
                    end
                end
            end
            S_CMD_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_ch;
                n_state   = S_CMD_WR;
            end
            S_CMD_WR: begin
                // Play and stop keep the step count and direction level.
                mem_we    = 1'b1;
                mem_waddr = r_ch;
                if (r_op == mdst_pkg::OP_PLAY) begin
                    mem_wdata = {rd_dir, rd_steps, {PERIOD_BITS{1'b0}}, r_period, 1'b1};
                end else begin
                    mem_wdata = {rd_dir, rd_steps, rd_tick, rd_period, 1'b0};
                end
                n_state = S_IDLE;
            end
            S_TICK: begin
                // Reads run one channel ahead of the write-back, so the two
                // ports never touch the same entry in one cycle.
                if (32'(r_cnt) < NUM_CHANNELS) begin
                    mem_re     = 1'b1;
                    mem_raddr  = r_cnt[IDX_W-1:0];
                    n_cnt      = r_cnt + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_cnt[IDX_W-1:0];
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pend_idx;
                    mem_wdata = {alu_dir, alu_steps, alu_tick, rd_period, rd_active};
                    for (int b = 0; b < MB; b++) begin
                        if (32'(r_pend_idx) == b) begin
                            n_step_acc[b] = alu_step;
                            n_dir_acc[b]  = alu_dir;
                        end
                    end
                end
                if (!(32'(r_cnt) < NUM_CHANNELS) && !r_pend) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_step  = r_step_acc;
                    n_out_dir   = r_dir_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_step  <= mdst_pkg::MAX_STEP_RESET;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_step <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_period   <= n_period;
        r_pend_idx <= n_pend_idx;
        r_step_acc <= n_step_acc;
        r_dir_acc  <= n_dir_acc;
        r_out_step <= n_out_step;
        r_out_dir  <= n_out_dir;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_dir, r_out_step};

`ifndef SYNTH
    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("memory read and write hit the same channel");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (32'(r_cnt) <= NUM_CHANNELS))
        else $error("tick sweep ran past the last channel");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the result stage");

    a_cmd_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMD_WR) |=> (r_state == S_IDLE && !mem_we))
        else $error("command write-back did not return to idle");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multi-channel step-pulse tone generator
// A directed table covers reset levels, zero and full periods, replay and stop
// of running channels and the unused op code. Randomized phases follow, each
// under its own step limit. Every tick result is checked against a local model
// of the counters or a typed row's masks. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam mdst_pkg::t_op OP_UNUSED     = 2'd3;
    localparam int            NCH           = mdst_pkg::DEF_NUM_CHANNELS;
    localparam int            SETTLE_CYCLES = 2 * (NCH + 3) + 4;
    localparam int            PHASE_ITEMS   = 145;
    localparam int            NUM_PHASES    = 6;
    localparam int            NUM_ROWS      = 20;

    typedef struct packed {
        logic [mdst_pkg::MASK_BITS-1:0] step_mask;
        logic [mdst_pkg::MASK_BITS-1:0] dir_mask;
    } t_tone_result;

    typedef struct packed {
        mdst_pkg::t_op                    op;
        logic [mdst_pkg::CH_BITS-1:0]     chan;
        logic [mdst_pkg::PERIOD_IN_W-1:0] period;
        logic                             typed;
        logic [mdst_pkg::MASK_BITS-1:0]   step_exp;
        logic [mdst_pkg::MASK_BITS-1:0]   dir_exp;
    } t_warmup_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mdst_pkg::MAX_BITS-1:0]   i_cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [mdst_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [mdst_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Local copy of the channel state.
    bit                               chan_running [NCH];
    logic [mdst_pkg::PERIOD_IN_W-1:0] chan_period  [NCH];
    logic [mdst_pkg::PERIOD_IN_W-1:0] chan_ticks   [NCH];
    logic [mdst_pkg::STEP_BITS-1:0]   chan_steps   [NCH];
    bit                               chan_forward [NCH];
    logic [mdst_pkg::MAX_BITS-1:0]    step_limit;

    t_tone_result pending_masks[$];
    t_warmup_row  warmup_rows [NUM_ROWS];

    bit src_gaps_on;
    bit sink_stalls_on;
    int fail_count;
    int results_checked;
    int requests_sent;
    int pulses_predicted;
    int reversals_predicted;

    multi_drive_step_tone_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !sink_stalls_on || ($urandom_range(0, 99) >= 18);
    end

    // Applies one request to the local state; returns 1 when a tick result is due.
    function automatic bit tone_advance(input mdst_pkg::t_op op,
                                        input logic [mdst_pkg::CH_BITS-1:0] ch,
                                        input logic [mdst_pkg::PERIOD_IN_W-1:0] per,
                                        output t_tone_result res);
        res = '0;
        if (op == mdst_pkg::OP_PLAY) begin
            chan_ticks[ch]   = '0;
            chan_period[ch]  = per;
            chan_running[ch] = 1'b1;
            return 1'b0;
        end
        if (op == mdst_pkg::OP_STOP) begin
            chan_running[ch] = 1'b0;
            return 1'b0;
        end
        if (op != mdst_pkg::OP_TICK)
            return 1'b0;
        for (int c = 0; c < NCH; c++) begin
            if (chan_running[c]) begin
                chan_ticks[c] = chan_ticks[c] + 1'b1;
                if (chan_ticks[c] >= chan_period[c]) begin
                    chan_steps[c] = chan_steps[c] + 1'b1;
                    if (chan_steps[c] > {1'b0, step_limit}) begin
                        chan_forward[c] = !chan_forward[c];
                        chan_steps[c]   = '0;
                        reversals_predicted++;
                    end
                    chan_ticks[c]    = '0;
                    res.step_mask[c] = 1'b1;
                    pulses_predicted++;
                end
            end
            res.dir_mask[c] = chan_forward[c];
        end
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input mdst_pkg::t_op op,
                                input logic [mdst_pkg::CH_BITS-1:0] ch,
                                input logic [mdst_pkg::PERIOD_IN_W-1:0] per,
                                input bit typed,
                                input logic [mdst_pkg::MASK_BITS-1:0] step_exp,
                                input logic [mdst_pkg::MASK_BITS-1:0] dir_exp);
        t_tone_result predicted;
        while (src_gaps_on && $urandom_range(0, 99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(mdst_pkg::IN_DATA_W - mdst_pkg::OP_BITS - mdst_pkg::CH_BITS
                            - mdst_pkg::PERIOD_IN_W){1'b0}}, per, ch, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        requests_sent++;
        if (tone_advance(op, ch, per, predicted)) begin
            if (typed)
                predicted = '{step_mask: step_exp, dir_mask: dir_exp};
            pending_masks = {pending_masks, predicted};
        end
        @(negedge i_clk);
    endtask

    task automatic random_request(output bit counted);
        int                               roll;
        mdst_pkg::t_op                    op;
        logic [mdst_pkg::PERIOD_IN_W-1:0] per;
        roll = $urandom_range(0, 99);
        if (roll < 58)
            op = mdst_pkg::OP_TICK;
        else if (roll < 82)
            op = mdst_pkg::OP_PLAY;
        else if (roll < 93)
            op = mdst_pkg::OP_STOP;
        else
            op = OP_UNUSED;
        // Short periods keep the channels stepping; a few long ones toggle the high bits.
        roll = $urandom_range(0, 99);
        if (roll < 70)
            per = mdst_pkg::PERIOD_IN_W'($urandom_range(0, 12));
        else if (roll < 90)
            per = mdst_pkg::PERIOD_IN_W'($urandom_range(0, 300));
        else
            per = mdst_pkg::PERIOD_IN_W'($urandom_range(0, 16383));
        send_request(op, mdst_pkg::CH_BITS'($urandom_range(0, NCH - 1)), per,
                     1'b0, '0, '0);
        counted = (op != OP_UNUSED);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_masks.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_step_limit(input logic [mdst_pkg::MAX_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        step_limit   = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_tone_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_masks.size() == 0) begin
                $error("result with no request pending: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_masks.pop_front();
                results_checked++;
                if (m_axis_tdata[7:0] !== want.step_mask) begin
                    $error("step_mask: expected %h, got %h", want.step_mask,
                           m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[15:8] !== want.dir_mask) begin
                    $error("direction_mask: expected %h, got %h", want.dir_mask,
                           m_axis_tdata[15:8]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic [mdst_pkg::MAX_BITS-1:0] limits [NUM_PHASES];
        int                            done_items;
        bit                            counted;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        step_limit     = mdst_pkg::MAX_STEP_RESET;
        for (int c = 0; c < NCH; c++) begin
            chan_running[c] = 1'b0;
            chan_period[c]  = '0;
            chan_ticks[c]   = '0;
            chan_steps[c]   = '0;
            chan_forward[c] = 1'b1;
        end

        warmup_rows = '{
            '{mdst_pkg::OP_TICK, 3'd0, 14'd0,     1'b1, 8'h00, 8'hFF},  // reset levels
            '{OP_UNUSED,         3'd7, 14'd16383, 1'b0, 8'h00, 8'h00},  // ignored
            '{mdst_pkg::OP_TICK, 3'd0, 14'd0,     1'b1, 8'h00, 8'hFF},
            '{mdst_pkg::OP_PLAY, 3'd0, 14'd0,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_TICK, 3'd0, 14'd0,     1'b1, 8'h01, 8'hFF},  // zero period
            '{mdst_pkg::OP_PLAY, 3'd7, 14'd16383, 1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_PLAY, 3'd3, 14'd2,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_TICK, 3'd0, 14'd0,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_TICK, 3'd0, 14'd0,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_PLAY, 3'd3, 14'd5,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_TICK, 3'd0, 14'd0,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_PLAY, 3'd3, 14'd1,     1'b0, 8'h00, 8'h00},  // replace a period
            '{mdst_pkg::OP_TICK, 3'd0, 14'd0,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_STOP, 3'd0, 14'd0,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_TICK, 3'd0, 14'd0,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_PLAY, 3'd0, 14'd0,     1'b0, 8'h00, 8'h00},  // step count survives
            '{mdst_pkg::OP_STOP, 3'd7, 14'd16383, 1'b0, 8'h00, 8'h00},
            '{OP_UNUSED,         3'd0, 14'd0,     1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_PLAY, 3'd1, 14'd8191,  1'b0, 8'h00, 8'h00},
            '{mdst_pkg::OP_TICK, 3'd0, 14'd0,     1'b0, 8'h00, 8'h00}
        };
        limits = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(1, 254)),
                   mdst_pkg::MAX_STEP_RESET, 8'($urandom_range(1, 254))};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_request(warmup_rows[r].op, warmup_rows[r].chan, warmup_rows[r].period,
                         warmup_rows[r].typed, warmup_rows[r].step_exp,
                         warmup_rows[r].dir_exp);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_step_limit(limits[p]);
            // The third phase runs with both sides always ready.
            src_gaps_on    = (p != 2);
            sink_stalls_on = (p != 2);
            done_items     = 0;
            while (done_items < PHASE_ITEMS) begin
                random_request(counted);
                if (counted)
                    done_items++;
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end
        drain_results();

        $display("Sent %0d requests over %0d step limits; checked %0d tick results.",
                 requests_sent, NUM_PHASES + 1, results_checked);
        $display("The results held %0d step pulses and %0d direction reversals.",
                 pulses_predicted, reversals_predicted);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
